FILE: sv/xor_checksum_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder modules.
`ifndef XOR_CHECKSUM_FRAME_DECODER_ASSERT_SVH
`define XOR_CHECKSUM_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/xcfd_pkg.sv
`default_nettype none

package xcfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;
    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] START_BYTE = 8'hFE;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_LONG = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] func_code;
        logic [15:0] payload_len;
        logic [6:0]  byte_index;
        logic [7:0]  data_byte;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/xor_checksum_frame_decoder.sv
`default_nettype none

// Decodes framed bytes from a serial link: start byte 0xFE, a 16-bit function code and a 16-bit
// payload length (most significant byte first), the payload and an XOR checksum byte. Every
// payload byte gives one word with its index, the checksum byte gives a good or bad word, and a
// length above MAX_PAYLOAD gives a length error word and drops the frame; a zero-length frame
// ends with no word. One byte is taken every cycle while in_stall is low, and its result word
// is registered in the output register, or in the skid entry while the output word is held;
// the frame state and running XOR are registered per byte taken. A two-entry output buffer
// lets input continue while a word waits, and in_stall rises only when both entries are full.
module xor_checksum_frame_decoder
    import xcfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [15:0]      func_code,
    output logic [15:0]      payload_len,
    output logic [6:0]       byte_index,
    output logic [7:0]       data_byte
);

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_FUNC_HI = 3'd1,
        PH_FUNC_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_DATA    = 3'd5,
        PH_SUM     = 3'd6
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [15:0]        func_reg, func_next;
    logic [15:0]        len_reg, len_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         xor_reg, xor_next;
    logic               accept;
    logic               full;
    logic               push;
    result_t            res;
    result_t            out_word;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        phase_next = phase_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        push       = 1'b0;
        res.kind        = KIND_DATA;
        res.byte_index  = 7'd0;
        res.data_byte   = 8'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        func_next  = 16'd0;
                        len_next   = 16'd0;
                        count_next = '0;
                        xor_next   = START_BYTE;
                        phase_next = PH_FUNC_HI;
                    end
                end
                PH_FUNC_HI:
                begin
                    func_next  = {rx_byte, 8'd0};
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_FUNC_LO;
                end
                PH_FUNC_LO:
                begin
                    func_next  = {func_reg[15:8], rx_byte};
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {rx_byte, 8'd0};
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], rx_byte};
                    xor_next = xor_reg ^ rx_byte;
                    if (len_next == 16'd0)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (len_next > 16'(MAX_PAYLOAD))
                    begin
                        res.kind   = KIND_LONG;
                        push       = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    xor_next       = xor_reg ^ rx_byte;
                    res.kind       = KIND_DATA;
                    res.byte_index = 7'(count_reg);
                    res.data_byte  = rx_byte;
                    push           = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    if (16'(count_next) == len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    res.kind      = (xor_reg == rx_byte) ? KIND_GOOD : KIND_BAD;
                    res.data_byte = rx_byte;
                    push          = 1'b1;
                    phase_next    = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
        res.func_code   = func_next;
        res.payload_len = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            func_reg  <= 16'd0;
            len_reg   <= 16'd0;
            count_reg <= '0;
            xor_reg   <= START_BYTE;
        end
        else
        begin
            phase_reg <= phase_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    xcfd_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign kind        = out_word.kind;
    assign func_code   = out_word.func_code;
    assign payload_len = out_word.payload_len;
    assign byte_index  = out_word.byte_index;
    assign data_byte   = out_word.data_byte;

    `include "xor_checksum_frame_decoder_assert.svh"

    `XCFD_ASSERT_SAME(a_data_len_bounds, phase_reg == PH_DATA,
        (16'(count_reg) < len_reg) && (len_reg <= 16'(MAX_PAYLOAD)),
        "Payload count or length out of range while taking payload.")
    `XCFD_ASSERT_NEXT(a_sum_returns_to_wait, accept && phase_reg == PH_SUM,
        phase_reg == PH_WAIT && out_valid,
        "Checksum byte did not end the frame with a result word.")

endmodule

`default_nettype wire

FILE: sv/xcfd_out_skid.sv
`default_nettype none

module xcfd_out_skid
    import xcfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_word,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_word
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_word_reg;
    result_t skid_word_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_word_reg <= push_word;
            end
            else
            begin
                skid_word_reg <= push_word;
            end
        end
    end

    `include "xor_checksum_frame_decoder_assert.svh"

    `XCFD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "Skid entry holds a word while the output register is empty.")
    `XCFD_ASSERT_SAME(a_no_push_when_full, skid_valid_reg, !push,
        "A word was pushed while both entries were full.")
    `XCFD_ASSERT_NEXT(a_stalled_full_holds, skid_valid_reg && out_stall,
        skid_valid_reg && out_valid_reg,
        "A stalled full buffer lost a word.")

endmodule

`default_nettype wire
